// ===== rtl/epq_pkg.sv =====
// ----------------------------------------------------------------------------
// epq_pkg
// Shared types and constants of the entry pool with priority queues.
// ----------------------------------------------------------------------------
package epq_pkg;

	localparam int unsigned NumEntriesDef = 32;
	localparam int unsigned NumQueuesDef  = 8;
	localparam int unsigned PrioBitsDef   = 8;

	localparam int unsigned CmdW   = 3;
	localparam int unsigned QidW   = 3;
	localparam int unsigned EntW   = 5;
	localparam int unsigned PrioW  = 8;
	localparam int unsigned StatW  = 2;

	typedef enum logic [CmdW-1:0] {
		CMD_ALLOC  = 3'd0,
		CMD_FREE   = 3'd1,
		CMD_EMPTY  = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_PEEK   = 3'd4,
		CMD_RMHEAD = 3'd5,
		CMD_RMENT  = 3'd6,
		CMD_TEST   = 3'd7
	} cmd_t;

	localparam logic [StatW-1:0] ST_OK   = 2'd0;
	localparam logic [StatW-1:0] ST_NONE = 2'd1;
	localparam logic [StatW-1:0] ST_ERR  = 2'd2;

endpackage

// ===== rtl/entry_pool_with_priority_queues.sv =====
// ----------------------------------------------------------------------------
// entry_pool_with_priority_queues
// Pool of entries with a free list and priority-ordered linked queues.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, cmd, queue_id, entry, priority_req
// out     | output    | out_valid, out_ready, status, result_entry, queue_empty
//
// A command is decoded and then steps through each link that it visits
// (read, wait, step); a sorted insert, a remove entry or an empty queue walks
// up to NUM_ENTRIES links through the link memory, which has one registered
// read port. The block returns to idle after each transfer of a result.
// After reset a clearing pass over all NUM_ENTRIES entries sets up the free chain
// and the location table; no item is taken meanwhile.
// A held result blocks the next command until it is transferred.
// ----------------------------------------------------------------------------
module entry_pool_with_priority_queues
	import epq_pkg::*;
#(
	parameter int unsigned NUM_ENTRIES = NumEntriesDef,
	parameter int unsigned NUM_QUEUES  = NumQueuesDef,
	parameter int unsigned PRIO_BITS   = PrioBitsDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CmdW-1:0]  cmd,
	input  logic [QidW-1:0]  queue_id,
	input  logic [EntW-1:0]  entry,
	input  logic [PrioW-1:0] priority_req,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [StatW-1:0] status,
	output logic [EntW-1:0]  result_entry,
	output logic             queue_empty
);

	localparam int unsigned AW = $clog2(NUM_ENTRIES);
	localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int unsigned CW = $clog2(NUM_ENTRIES + 1);
	localparam int unsigned LW = $clog2(NUM_QUEUES + 2);
	localparam logic [LW-1:0] LOC_ALLOC = LW'(NUM_QUEUES);
	localparam logic [LW-1:0] LOC_FREE  = LW'(NUM_QUEUES + 1);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DECODE, S_RD, S_WAIT, S_STEP, S_FIN, S_WR2, S_OUT
	} state_t;

	typedef enum logic [2:0] {W_NONE, W_INSERT, W_UNLINK, W_CLEAR} walk_t;

	state_t state_q;
	walk_t  walk_q;

	logic [CmdW-1:0]      cmd_q;
	logic [QidW-1:0]      qid_q;
	logic [EntW-1:0]      ent_q;
	logic [PRIO_BITS-1:0] prio_q;

	logic [AW-1:0] qhead_q [NUM_QUEUES];
	logic [AW-1:0] qtail_q [NUM_QUEUES];
	logic [CW-1:0] qcnt_q  [NUM_QUEUES];
	logic [AW-1:0] fhead_q, ftail_q;
	logic [CW-1:0] fcnt_q;

	logic [AW-1:0] cur_q, prev_q, init_q;
	logic          have_prev_q;
	logic [CW-1:0] idx_q;

	logic [StatW-1:0] status_q;
	logic [EntW-1:0]  res_q;
	logic             qempty_q;

	// Link, priority and location memories.
	logic          lk_we, pr_we, lc_we;
	logic [AW-1:0] lk_wa, lk_ra, pr_wa, pr_ra, lc_wa, lc_ra;
	logic [AW-1:0] lk_wd, lk_rd;
	logic [PRIO_BITS-1:0] pr_wd, pr_rd;
	logic [LW-1:0] lc_wd, lc_rd;

	epq_ram #(.WIDTH(AW), .DEPTH(NUM_ENTRIES)) u_link (
		.clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
	epq_ram #(.WIDTH(PRIO_BITS), .DEPTH(NUM_ENTRIES)) u_prio (
		.clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd));
	epq_ram #(.WIDTH(LW), .DEPTH(NUM_ENTRIES)) u_loc (
		.clk(clk), .we(lc_we), .waddr(lc_wa), .wdata(lc_wd), .raddr(lc_ra), .rdata(lc_rd));

	logic          qok, eok;
	logic [QW-1:0] qi;
	logic [AW-1:0] ea;

	assign qok = 32'(qid_q) < NUM_QUEUES;
	assign eok = 32'(ent_q) < NUM_ENTRIES;
	assign qi  = QW'(qid_q);
	assign ea  = AW'(ent_q);

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = (state_q == S_OUT);
	assign status       = status_q;
	assign result_entry = res_q;
	assign queue_empty  = qempty_q;

	// Read addresses: during a walk the link and priority of cur are read.
	always_comb begin
		lk_ra = cur_q;
		pr_ra = cur_q;
		lc_ra = ea;
		if (state_q == S_DECODE && cmd_q == CMD_ALLOC) begin
			lk_ra = fhead_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			walk_q      <= W_NONE;
			init_q      <= '0;
			fhead_q     <= AW'(NUM_ENTRIES - 1);
			ftail_q     <= '0;
			fcnt_q      <= CW'(NUM_ENTRIES);
			cur_q       <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			idx_q       <= '0;
			status_q    <= ST_OK;
			res_q       <= '0;
			qempty_q    <= 1'b0;
			lk_we       <= 1'b0;
			pr_we       <= 1'b0;
			lc_we       <= 1'b0;
			lk_wa       <= '0;
			pr_wa       <= '0;
			lc_wa       <= '0;
			lk_wd       <= '0;
			pr_wd       <= '0;
			lc_wd       <= '0;
			cmd_q       <= '0;
			qid_q       <= '0;
			ent_q       <= '0;
			prio_q      <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				qhead_q[i] <= '0;
				qtail_q[i] <= '0;
				qcnt_q[i]  <= '0;
			end
		end else begin
			lk_we <= 1'b0;
			pr_we <= 1'b0;
			lc_we <= 1'b0;
			case (state_q)
				S_INIT: begin
					lk_we  <= 1'b1;
					lk_wa  <= init_q;
					lk_wd  <= (init_q == '0) ? '0 : init_q - AW'(1);
					pr_we  <= 1'b1;
					pr_wa  <= init_q;
					pr_wd  <= '0;
					lc_we  <= 1'b1;
					lc_wa  <= init_q;
					lc_wd  <= LOC_FREE;
					init_q <= init_q + AW'(1);
					if (32'(init_q) == NUM_ENTRIES - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						qid_q   <= queue_id;
						ent_q   <= entry;
						prio_q  <= PRIO_BITS'(priority_req);
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					status_q    <= ST_OK;
					res_q       <= '0;
					cur_q       <= qhead_q[qi];
					have_prev_q <= 1'b0;
					prev_q      <= '0;
					idx_q       <= '0;
					walk_q      <= W_NONE;
					if (cmd_q == CMD_ALLOC || cmd_q == CMD_FREE || cmd_q == CMD_INSERT) begin
						state_q <= S_RD;
					end else if (!qok) begin
						status_q <= ST_ERR;
						state_q  <= S_FIN;
					end else begin
						case (cmd_q)
							CMD_EMPTY: begin
								walk_q  <= W_CLEAR;
								state_q <= S_RD;
							end
							CMD_PEEK, CMD_RMHEAD: begin
								if (qcnt_q[qi] == '0) begin
									status_q <= ST_NONE;
									state_q  <= S_FIN;
								end else begin
									res_q <= EntW'(qhead_q[qi]);
									if (cmd_q == CMD_RMHEAD) begin
										walk_q  <= W_UNLINK;
										ent_q   <= EntW'(qhead_q[qi]);
										state_q <= S_RD;
									end else begin
										state_q <= S_FIN;
									end
								end
							end
							CMD_RMENT: begin
								if (qcnt_q[qi] == '0 || !eok) begin
									status_q <= ST_NONE;
									state_q  <= S_FIN;
								end else begin
									walk_q  <= W_UNLINK;
									state_q <= S_RD;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_RD: begin
					// Read data for cur (link, priority) and for the named entry's location.
					state_q <= S_WAIT;
					if (walk_q == W_NONE) begin
						case (cmd_q)
							CMD_ALLOC: begin
								if (fcnt_q == '0) begin
									status_q <= ST_NONE;
								end else begin
									res_q   <= EntW'(fhead_q);
									fhead_q <= lk_rd;
									fcnt_q  <= fcnt_q - CW'(1);
									if (fcnt_q == CW'(1)) begin
										fhead_q <= '0;
										ftail_q <= '0;
									end
									lc_we <= 1'b1;
									lc_wa <= fhead_q;
									lc_wd <= LOC_ALLOC;
									pr_we <= 1'b1;
									pr_wa <= fhead_q;
									pr_wd <= '0;
								end
								state_q <= S_FIN;
							end
							default: ;
						endcase
					end
				end
				S_WAIT: begin
					state_q <= S_STEP;
					if (walk_q == W_NONE) begin
						if (!eok || lc_rd != LOC_ALLOC) begin
							status_q <= ST_ERR;
							state_q  <= S_FIN;
						end else if (cmd_q == CMD_FREE) begin
							if (fcnt_q == '0) begin
								fhead_q <= ea;
							end else begin
								lk_we <= 1'b1;
								lk_wa <= ftail_q;
								lk_wd <= ea;
							end
							ftail_q <= ea;
							fcnt_q  <= fcnt_q + CW'(1);
							lc_we   <= 1'b1;
							lc_wa   <= ea;
							lc_wd   <= LOC_FREE;
							state_q <= S_WR2;
						end else if (!qok) begin
							status_q <= ST_ERR;
							state_q  <= S_FIN;
						end else begin
							pr_we  <= 1'b1;
							pr_wa  <= ea;
							pr_wd  <= prio_q;
							lc_we  <= 1'b1;
							lc_wa  <= ea;
							lc_wd  <= LW'(qid_q);
							walk_q <= W_INSERT;
							state_q <= S_RD;
						end
					end
				end
				S_STEP: begin
					// One link per visit: lk_rd and pr_rd belong to cur_q.
					state_q <= S_RD;
					case (walk_q)
						W_CLEAR: begin
							if (idx_q == qcnt_q[qi]) begin
								qhead_q[qi] <= '0;
								qtail_q[qi] <= '0;
								qcnt_q[qi]  <= '0;
								state_q     <= S_FIN;
							end else begin
								lc_we <= 1'b1;
								lc_wa <= cur_q;
								lc_wd <= LOC_ALLOC;
								cur_q <= lk_rd;
								idx_q <= idx_q + CW'(1);
							end
						end
						W_INSERT: begin
							if (idx_q == qcnt_q[qi] || pr_rd < prio_q) begin
								state_q <= S_WR2;
								if (qcnt_q[qi] == '0 || idx_q == qcnt_q[qi]) begin
									lk_we <= 1'b1;
									lk_wa <= ea;
									lk_wd <= '0;
									if (qcnt_q[qi] != '0) begin
										prev_q <= qtail_q[qi];
										have_prev_q <= 1'b1;
									end else begin
										qhead_q[qi] <= ea;
										have_prev_q <= 1'b0;
									end
									qtail_q[qi] <= ea;
								end else begin
									lk_we <= 1'b1;
									lk_wa <= ea;
									lk_wd <= cur_q;
									if (!have_prev_q) begin
										qhead_q[qi] <= ea;
									end
								end
								qcnt_q[qi] <= qcnt_q[qi] + CW'(1);
							end else begin
								prev_q      <= cur_q;
								have_prev_q <= 1'b1;
								cur_q       <= lk_rd;
								idx_q       <= idx_q + CW'(1);
							end
						end
						W_UNLINK: begin
							if (idx_q == qcnt_q[qi]) begin
								status_q <= ST_NONE;
								res_q    <= '0;
								state_q  <= S_FIN;
							end else if (cur_q == ea) begin
								if (!have_prev_q) begin
									qhead_q[qi] <= lk_rd;
								end else begin
									lk_we <= 1'b1;
									lk_wa <= prev_q;
									lk_wd <= lk_rd;
								end
								if (qtail_q[qi] == cur_q) begin
									qtail_q[qi] <= prev_q;
								end
								qcnt_q[qi] <= qcnt_q[qi] - CW'(1);
								if (qcnt_q[qi] == CW'(1)) begin
									qhead_q[qi] <= '0;
									qtail_q[qi] <= '0;
								end
								lc_we    <= 1'b1;
								lc_wa    <= cur_q;
								lc_wd    <= LOC_ALLOC;
								res_q    <= EntW'(cur_q);
								state_q  <= S_FIN;
							end else begin
								prev_q      <= cur_q;
								have_prev_q <= 1'b1;
								cur_q       <= lk_rd;
								idx_q       <= idx_q + CW'(1);
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_WR2: begin
					// Second link write of a free or an insert.
					state_q <= S_FIN;
					if (cmd_q == CMD_FREE) begin
						lk_we <= 1'b1;
						lk_wa <= ea;
						lk_wd <= '0;
					end else if (have_prev_q) begin
						lk_we <= 1'b1;
						lk_wa <= prev_q;
						lk_wd <= ea;
					end
				end
				S_FIN: begin
					qempty_q <= qok ? (qcnt_q[qi] == '0) : 1'b1;
					if (status_q != ST_OK) begin
						res_q <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> state_q == S_DECODE)
		else $error("Accepted command did not start decoding.");
	assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= CW'(NUM_ENTRIES))
		else $error("Free count exceeds the pool size.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(status_q))
		else $error("Held result changed before transfer.");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("Input taken while a result is pending.");

endmodule

// ===== rtl/epq_ram.sv =====
// ----------------------------------------------------------------------------
// epq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module epq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed commands into the entry pool with priority
// queues and checks every result against a behavioral model of the pool.
// ----------------------------------------------------------------------------
module testbench;
	import epq_pkg::*;

	localparam int NE = 32;
	localparam int NQ = 8;
	localparam int LOC_ALLOC = NQ;
	localparam int LOC_FREE = NQ + 1;

	typedef struct packed {
		logic [StatW-1:0] status;
		logic [EntW-1:0]  result_entry;
		logic             queue_empty;
	} pool_result_t;

	class pool_scoreboard;
		int nxt[NE];
		int prio[NE];
		int loc[NE];
		int qhead[NQ];
		int qtail[NQ];
		int qcount[NQ];
		int fhead;
		int ftail;
		int fcount;
		pool_result_t pending[$];
		int errors;

		function void init();
			for (int i = 0; i < NE; i++) begin
				nxt[i] = (i == 0) ? 0 : i - 1;
				prio[i] = 0;
				loc[i] = LOC_FREE;
			end
			for (int i = 0; i < NQ; i++) begin
				qhead[i] = 0;
				qtail[i] = 0;
				qcount[i] = 0;
			end
			fhead = NE - 1;
			ftail = 0;
			fcount = NE;
			errors = 0;
		endfunction

		function bit unlink(int q, int e);
			int cur;
			int prev;
			bit hp;
			int i;
			cur = qhead[q];
			prev = 0;
			hp = 0;
			for (i = 0; i < qcount[q]; i++) begin
				if (cur == e)
					break;
				prev = cur;
				hp = 1;
				cur = nxt[cur];
			end
			if (i == qcount[q])
				return 0;
			if (!hp)
				qhead[q] = nxt[cur];
			else
				nxt[prev] = nxt[cur];
			if (qtail[q] == cur)
				qtail[q] = prev;
			qcount[q]--;
			if (qcount[q] == 0) begin
				qhead[q] = 0;
				qtail[q] = 0;
			end
			loc[cur] = LOC_ALLOC;
			return 1;
		endfunction

		function void insert(int q, int e, int pr);
			int cur;
			int prev;
			bit hp;
			int i;
			cur = qhead[q];
			prev = 0;
			hp = 0;
			prio[e] = pr;
			loc[e] = q;
			for (i = 0; i < qcount[q]; i++) begin
				if (prio[cur] < pr)
					break;
				prev = cur;
				hp = 1;
				cur = nxt[cur];
			end
			if (qcount[q] == 0) begin
				qhead[q] = e;
				qtail[q] = e;
				nxt[e] = 0;
			end else if (i == qcount[q]) begin
				nxt[qtail[q]] = e;
				qtail[q] = e;
				nxt[e] = 0;
			end else if (!hp) begin
				nxt[e] = qhead[q];
				qhead[q] = e;
			end else begin
				nxt[e] = cur;
				nxt[prev] = e;
			end
			qcount[q]++;
		endfunction

		function void note_command(cmd_t c, int q, int e, int pr);
			pool_result_t r;
			int st;
			int res;
			int cur;
			st = ST_OK;
			res = 0;
			case (c)
				CMD_ALLOC: begin
					if (fcount == 0) begin
						st = ST_NONE;
					end else begin
						res = fhead;
						fhead = nxt[res];
						fcount--;
						if (fcount == 0) begin
							fhead = 0;
							ftail = 0;
						end
						loc[res] = LOC_ALLOC;
						prio[res] = 0;
					end
				end
				CMD_FREE: begin
					if (loc[e] != LOC_ALLOC) begin
						st = ST_ERR;
					end else begin
						if (fcount == 0)
							fhead = e;
						else
							nxt[ftail] = e;
						ftail = e;
						nxt[e] = 0;
						fcount++;
						loc[e] = LOC_FREE;
					end
				end
				CMD_EMPTY: begin
					cur = qhead[q];
					for (int i = 0; i < qcount[q]; i++) begin
						loc[cur] = LOC_ALLOC;
						cur = nxt[cur];
					end
					qhead[q] = 0;
					qtail[q] = 0;
					qcount[q] = 0;
				end
				CMD_INSERT: begin
					if (loc[e] != LOC_ALLOC)
						st = ST_ERR;
					else
						insert(q, e, pr);
				end
				CMD_PEEK, CMD_RMHEAD: begin
					if (qcount[q] == 0) begin
						st = ST_NONE;
					end else begin
						res = qhead[q];
						if (c == CMD_RMHEAD)
							void'(unlink(q, res));
					end
				end
				CMD_RMENT: begin
					if (qcount[q] == 0 || !unlink(q, e))
						st = ST_NONE;
					else
						res = e;
				end
				default: ;
			endcase
			r.status = StatW'(st);
			r.result_entry = (st == ST_OK) ? EntW'(res) : '0;
			r.queue_empty = (qcount[q] == 0);
			pending.push_back(r);
		endfunction

		function void check_result(pool_result_t got);
			pool_result_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$error("status expected %0d actual %0d", exp.status, got.status);
				errors++;
			end
			if (got.result_entry !== exp.result_entry) begin
				$error("result_entry expected %0d actual %0d", exp.result_entry,
					got.result_entry);
				errors++;
			end
			if (got.queue_empty !== exp.queue_empty) begin
				$error("queue_empty expected %0d actual %0d", exp.queue_empty,
					got.queue_empty);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [CmdW-1:0] cmd;
	logic [QidW-1:0] queue_id;
	logic [EntW-1:0] entry;
	logic [PrioW-1:0] priority_req;
	logic out_valid;
	logic out_ready;
	logic [StatW-1:0] status;
	logic [EntW-1:0] result_entry;
	logic queue_empty;

	pool_scoreboard pool;
	bit quiet_phase;
	int results_seen;

	entry_pool_with_priority_queues dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .queue_id(queue_id), .entry(entry), .priority_req(priority_req),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.result_entry(result_entry), .queue_empty(queue_empty)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("testbench: errors");
		$finish;
	end

	// Valid stays high from one command to the next unless an idle burst or a drain drops it.
	task automatic send_command(cmd_t c, int q, int e, int pr);
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		cmd <= c;
		queue_id <= QidW'(q);
		entry <= EntW'(e);
		priority_req <= PrioW'(pr);
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		pool.note_command(c, q & (NQ - 1), e & (NE - 1), pr & 255);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(negedge clk);
		while (pool.pending.size() != 0)
			@(negedge clk);
	endtask

	// Pick an entry that the model currently holds in the given state, or any.
	function automatic int pick_entry(int want);
		int cand[$];
		for (int i = 0; i < NE; i++)
			if (pool.loc[i] == want)
				cand.push_back(i);
		if (cand.size() == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, NE - 1);
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			pool.check_result({status, result_entry, queue_empty});
			results_seen++;
		end
	end

	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (quiet_phase) begin
				out_ready <= 1;
			end else if ($urandom_range(0, 7) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	initial begin
		int r;
		int q;
		int waited;
		pool = new();
		pool.init();
		quiet_phase = 0;
		results_seen = 0;
		in_valid = 0;
		cmd = CMD_ALLOC;
		queue_id = 0;
		entry = 0;
		priority_req = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: drain the pool, misuse, sorted inserts and repairs.
		send_command(CMD_PEEK, 0, 0, 0);
		send_command(CMD_RMHEAD, 7, 0, 0);
		send_command(CMD_RMENT, 3, 31, 0);
		send_command(CMD_FREE, 0, 31, 0);
		for (int i = 0; i < NE; i++)
			send_command(CMD_ALLOC, 0, 0, 0);
		send_command(CMD_ALLOC, 0, 0, 0);
		send_command(CMD_INSERT, 7, 31, 255);
		send_command(CMD_INSERT, 7, 30, 0);
		send_command(CMD_INSERT, 7, 29, 255);
		send_command(CMD_INSERT, 7, 28, 128);
		send_command(CMD_INSERT, 7, 31, 5);
		send_command(CMD_FREE, 0, 30, 0);
		send_command(CMD_TEST, 7, 0, 0);
		send_command(CMD_RMENT, 7, 28, 0);
		send_command(CMD_RMENT, 7, 0, 0);
		send_command(CMD_PEEK, 7, 0, 0);
		send_command(CMD_RMHEAD, 7, 0, 0);
		send_command(CMD_EMPTY, 7, 0, 0);
		send_command(CMD_TEST, 7, 0, 0);
		send_command(CMD_FREE, 0, 30, 0);
		send_command(CMD_FREE, 0, 0, 0);
		send_command(CMD_ALLOC, 0, 0, 0);
		wait_drained();

		for (int n = 0; n < 400; n++) begin
			if (n == 340)
				quiet_phase = 1;
			if (n == 200)
				wait_drained();
			q = $urandom_range(0, NQ - 1);
			r = $urandom_range(0, 99);
			if (r < 20)
				send_command(CMD_ALLOC, q, $urandom, $urandom);
			else if (r < 32)
				send_command(CMD_FREE, q, pick_entry(LOC_ALLOC), $urandom);
			else if (r < 35)
				send_command(CMD_EMPTY, q, $urandom, $urandom);
			else if (r < 62)
				send_command(CMD_INSERT, q, pick_entry(LOC_ALLOC),
					($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255)));
			else if (r < 70)
				send_command(CMD_PEEK, q, $urandom, $urandom);
			else if (r < 82)
				send_command(CMD_RMHEAD, q, $urandom, $urandom);
			else if (r < 94)
				send_command(CMD_RMENT, q, pick_entry(q), $urandom);
			else
				send_command(CMD_TEST, q, $urandom, $urandom);
		end
		in_valid <= 0;

		waited = 0;
		while (pool.pending.size() != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (200) @(negedge clk);
		$display("Covered directed misuse, pool exhaustion and sorted queues, plus");
		$display("400 random commands; %0d results checked.", results_seen);
		if (pool.errors == 0 && pool.pending.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
